// ===== rtl/core/rcs_pkg.sv =====
// Shared types, constants and command codes for the region channel statistics block.
package rcs_pkg;

    localparam int CHANNELS         = 3;
    localparam int MAX_PIXELS_DEF   = 1048576;
    localparam int COUNT_W          = 21;
    localparam logic [COUNT_W-1:0] COUNT_FIELD_MAX = '1;
    localparam int MEAN_BITS        = 8;
    localparam int SD_BITS          = 16;
    localparam int FRAC_SHIFT       = 16;

    typedef struct packed {
        logic [7:0] chan0_value;
        logic [7:0] chan1_value;
        logic [7:0] chan2_value;
        logic       last_pixel;
    } rcs_pixel_t;

    typedef struct packed {
        logic [1:0]         channel;
        logic [COUNT_W-1:0] pixel_count;
        logic [7:0]         mean;
        logic [15:0]        stddev_q8;
        logic [7:0]         minimum;
        logic [7:0]         maximum;
        logic               overflow;
        logic               last_result;
    } rcs_result_t;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_LOAD,
        ST_DIVM,
        ST_MULA,
        ST_MULB,
        ST_PREP,
        ST_SQRT,
        ST_FIX,
        ST_DIVS,
        ST_EMIT
    } rcs_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACC,
        OP_LOAD,
        OP_DIVM,
        OP_MULA,
        OP_MULB,
        OP_PREP,
        OP_SQRT,
        OP_FIX,
        OP_DIVS,
        OP_EMIT
    } rcs_op_t;

    typedef struct packed {
        rcs_op_t    op;
        logic [1:0] ch;
        logic       clear;
    } rcs_cmd_t;

endpackage

// ===== rtl/core/rcs_stream_if.sv =====
// Valid/ready stream interface carrying one item per handshake.
interface rcs_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/rcs_ctrl.sv =====
// Controller state machine sequencing accumulation, arithmetic steps and emission.
module rcs_ctrl #(
    parameter int IW = 6,
    parameter int CW = 21
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output rcs_pkg::rcs_cmd_t cmd,
    output logic [IW-1:0]     idx
);
    import rcs_pkg::*;

    localparam int SW = CW + 8;
    localparam int RW = CW + 16;

    rcs_state_t    state_reg, state_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [1:0]    ch_reg, ch_next;
    logic          ov_reg, ov_next;
    logic          slot_free;

    assign slot_free = !ov_reg || out_ready;

    // true when the loop counter c has reached the last value of a loop of len steps, len - 1
    function automatic logic done_at(input logic [IW-1:0] c, input int len);
        return c == IW'(len - 1);
    endfunction

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ch_next    = ch_reg;
        ov_next    = ov_reg && !out_ready;
        case (state_reg)
            ST_ACC:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_LOAD;
                    ch_next    = '0;
                end
            end
            ST_LOAD: begin state_next = ST_DIVM; cnt_next = '0; end
            ST_DIVM:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (done_at(cnt_reg, MEAN_BITS)) begin state_next = ST_MULA; cnt_next = '0; end
            end
            ST_MULA:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (done_at(cnt_reg, CW)) begin state_next = ST_MULB; cnt_next = '0; end
            end
            ST_MULB:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (done_at(cnt_reg, SW)) begin state_next = ST_PREP; cnt_next = '0; end
            end
            ST_PREP: state_next = ST_SQRT;
            ST_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (done_at(cnt_reg, RW)) begin state_next = ST_FIX; cnt_next = '0; end
            end
            ST_FIX: state_next = ST_DIVS;
            ST_DIVS:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (done_at(cnt_reg, SD_BITS)) begin state_next = ST_EMIT; cnt_next = '0; end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    if (ch_reg == 2'(CHANNELS - 1))
                        state_next = ST_ACC;
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd.op    = OP_NONE;
        cmd.ch    = ch_reg;
        cmd.clear = 1'b0;
        idx       = cnt_reg;
        case (state_reg)
            ST_ACC:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = OP_ACC;
            end
            ST_LOAD: cmd.op = OP_LOAD;
            ST_DIVM: cmd.op = OP_DIVM;
            ST_MULA: cmd.op = OP_MULA;
            ST_MULB: cmd.op = OP_MULB;
            ST_PREP: cmd.op = OP_PREP;
            ST_SQRT: cmd.op = OP_SQRT;
            ST_FIX:  cmd.op = OP_FIX;
            ST_DIVS: cmd.op = OP_DIVS;
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.op    = OP_EMIT;
                    cmd.clear = (ch_reg == 2'(CHANNELS - 1));
                end
            end
            default: cmd.op = OP_NONE;
        endcase
    end

    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            cnt_reg   <= '0;
            ch_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ch_reg    <= ch_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// ===== rtl/core/rcs_datapath.sv =====
// Accumulators, shared shift-add multiplier, divider, square root and result register.
module rcs_datapath #(
    parameter int MAX_PIXELS = rcs_pkg::MAX_PIXELS_DEF,
    parameter int CW = 21,
    parameter int IW = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rcs_pkg::rcs_cmd_t    cmd,
    input  logic [IW-1:0]        idx,
    input  rcs_pkg::rcs_pixel_t  pix,
    output rcs_pkg::rcs_result_t res
);
    import rcs_pkg::*;

    localparam int SW = CW + 8;
    localparam int QW = CW + 16;
    localparam int RW = CW + 16;
    localparam int OW = 2 * RW;

    logic [SW-1:0] sum_reg   [CHANNELS];
    logic [QW-1:0] sumsq_reg [CHANNELS];
    logic [7:0]    min_reg   [CHANNELS];
    logic [7:0]    max_reg   [CHANNELS];
    logic [CW-1:0] seen_reg;
    logic          ovf_reg;

    logic [OW-1:0] op_reg;
    logic [OW-1:0] root_reg;
    logic [RW-1:0] rem_reg;
    logic [15:0]   q_reg;
    logic [7:0]    mean_reg;
    rcs_result_t   res_reg;

    logic [7:0]    sample [CHANNELS];
    logic [SW-1:0] s_sel;
    logic [QW-1:0] q_sel;
    logic [2:0]    sh_m;
    logic [3:0]    sh_s;
    logic [RW-1:0] dn_m, dn_s;
    logic [OW-1:0] one, trial;
    logic [CW+COUNT_W-1:0] n_wide;

    assign sample[0] = pix.chan0_value;
    assign sample[1] = pix.chan1_value;
    assign sample[2] = pix.chan2_value;

    always_comb
    begin
        s_sel  = sum_reg[0];
        q_sel  = sumsq_reg[0];
        if (cmd.ch == 2'd1) begin s_sel = sum_reg[1]; q_sel = sumsq_reg[1]; end
        if (cmd.ch == 2'd2) begin s_sel = sum_reg[2]; q_sel = sumsq_reg[2]; end
        sh_m   = 3'(3'd7 - idx[2:0]);
        sh_s   = 4'(4'd15 - idx[3:0]);
        dn_m   = RW'(seen_reg) << sh_m;
        dn_s   = RW'(seen_reg) << sh_s;
        one    = OW'(1) << (2 * (RW - 1 - int'(idx)));
        trial  = root_reg + one;
        n_wide = (CW+COUNT_W)'(seen_reg);
    end

    // accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c]   <= '0;
                sumsq_reg[c] <= '0;
                min_reg[c]   <= '0;
                max_reg[c]   <= '0;
            end
            seen_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (cmd.op == OP_ACC)
        begin
            if (seen_reg >= CW'(MAX_PIXELS))
                ovf_reg <= 1'b1;
            else
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    sum_reg[c]   <= sum_reg[c] + SW'(sample[c]);
                    sumsq_reg[c] <= sumsq_reg[c] + QW'(sample[c]) * QW'(sample[c]);
                    if (seen_reg == '0 || sample[c] < min_reg[c]) min_reg[c] <= sample[c];
                    if (seen_reg == '0 || sample[c] > max_reg[c]) max_reg[c] <= sample[c];
                end
                seen_reg <= seen_reg + 1'b1;
            end
        end
        else if (cmd.op == OP_EMIT && cmd.clear)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c]   <= '0;
                sumsq_reg[c] <= '0;
                min_reg[c]   <= '0;
                max_reg[c]   <= '0;
            end
            seen_reg <= '0;
            ovf_reg  <= 1'b0;
        end
    end

    // finishing arithmetic, one step a cycle
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                rem_reg <= RW'(s_sel);
                q_reg   <= '0;
                op_reg  <= '0;
            end
            OP_DIVM:
            begin
                if (rem_reg >= dn_m)
                begin
                    rem_reg <= rem_reg - dn_m;
                    q_reg   <= q_reg | (16'(1) << sh_m);
                end
            end
            OP_MULA:
                if (1'(seen_reg >> idx)) op_reg <= op_reg + (OW'(q_sel) << idx);
            OP_MULB:
                if (1'(s_sel >> idx)) op_reg <= op_reg - (OW'(s_sel) << idx);
            OP_PREP:
            begin
                mean_reg <= q_reg[7:0];
                op_reg   <= op_reg << FRAC_SHIFT;
                root_reg <= '0;
            end
            OP_SQRT:
            begin
                if (op_reg >= trial)
                begin
                    op_reg   <= op_reg - trial;
                    root_reg <= (root_reg >> 1) + one;
                end
                else
                    root_reg <= root_reg >> 1;
            end
            OP_FIX:
            begin
                rem_reg <= root_reg[RW-1:0];
                q_reg   <= '0;
            end
            OP_DIVS:
            begin
                if (rem_reg >= dn_s)
                begin
                    rem_reg <= rem_reg - dn_s;
                    q_reg   <= q_reg | (16'(1) << sh_s);
                end
            end
            OP_EMIT:
            begin
                res_reg.channel   <= cmd.ch;
                res_reg.pixel_count <= (n_wide > (CW+COUNT_W)'(COUNT_FIELD_MAX))
                                     ? COUNT_FIELD_MAX : n_wide[COUNT_W-1:0];
                res_reg.mean      <= mean_reg;
                res_reg.stddev_q8 <= q_reg;
                res_reg.minimum   <= min_reg[cmd.ch];
                res_reg.maximum   <= max_reg[cmd.ch];
                res_reg.overflow  <= ovf_reg;
                res_reg.last_result <= cmd.clear;
            end
            default: ;
        endcase
    end

    assign res = res_reg;

endmodule

// ===== rtl/core/region_channel_statistics.sv =====
// Top level: per-region mean, standard deviation, minimum and maximum of three channels.
// Pixels: one item a cycle while accumulating; the last pixel closes the region.
// Results: worked out per channel by serial divide, shift-add multiply and one-bit-a-cycle
//   square root (CW = clog2(MAX_PIXELS+1)); emission waits while the previous result
//   still sits in the output register; three results a region.
// No pixel is taken while results are being worked out; the final result may wait
//   in the output register while the next region streams in.
// Reset (rst_n, asynchronous, active low) clears all accumulators and the controller.
module region_channel_statistics #(
    parameter int MAX_PIXELS = rcs_pkg::MAX_PIXELS_DEF
) (
    input logic clk,
    input logic rst_n,
    rcs_stream_if.sink   pixel,
    rcs_stream_if.source result
);
    import rcs_pkg::*;

    // pixel count width and the widest loop, the square root, set the counter width
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int IW = $clog2(CW + 16);

    rcs_cmd_t      cmd;
    logic [IW-1:0] idx;
    rcs_pixel_t    pix;
    rcs_result_t   res;

    assign pix = pixel.data;

    // sequence the work: accumulate, then per channel divide, multiply, root, divide, emit
    rcs_ctrl #(
        .IW (IW),
        .CW (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_last   (pix.last_pixel),
        .in_ready  (pixel.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .idx       (idx)
    );

    // hold the sums and run the arithmetic steps the controller commands
    rcs_datapath #(
        .MAX_PIXELS (MAX_PIXELS),
        .CW         (CW),
        .IW         (IW)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .idx   (idx),
        .pix   (pix),
        .res   (res)
    );

    assign result.data = res;

endmodule
